// ===== rtl/arwf_pkg.sv =====
package arwf_pkg;

   // ring geometry (power of two)
   localparam int RING_FRAMES = 1024;
   localparam int RING_AW     = $clog2(RING_FRAMES);
   localparam int CNT_W       = RING_AW + 1;
   localparam int HALF_RING   = RING_FRAMES / 2;

   // rate control
   localparam int NOMINAL_FRAMES = 48;
   localparam int GUARD_BAND     = 2 * NOMINAL_FRAMES;
   localparam int FB_W           = 20;
   localparam int FB_FRAC        = 14;
   localparam int FB_GAIN_SH     = 3;
   localparam int FB_MAX_CORR    = 4096;
   localparam int CORR_W         = CNT_W + FB_GAIN_SH + 1;
   localparam logic [FB_W-1:0] FB_NOMINAL = FB_W'(NOMINAL_FRAMES << FB_FRAC);

   // payload widths
   localparam int SAMPLE_W = 16;
   localparam int FRAME_W  = 2 * SAMPLE_W;
   localparam int COUNT_W  = 6;
   localparam int OP_W     = 3;

   // register port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE   = 3'd0,
      OP_TICK    = 3'd1,
      OP_RESTART = 3'd2,
      OP_READ    = 3'd3,
      OP_STOP    = 3'd4
   } op_type;

   typedef enum logic {
      CSR_RING_ATTACHED = 1'b0,
      CSR_MUTE          = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [OP_W-1:0]             op;
      logic signed [SAMPLE_W-1:0]  left;
      logic signed [SAMPLE_W-1:0]  right;
      logic                        first;
      logic [COUNT_W-1:0]          count;
      logic [RING_AW-1:0]          rd;
   } item_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  play_left;
      logic signed [SAMPLE_W-1:0]  play_right;
      logic [FB_W-1:0]             feedback;
      logic [RING_AW-1:0]          fill;
      logic                        restarted;
   } result_type;

   typedef struct packed {
      logic attached;
      logic mute;
      logic attach_wr;
   } cfg_type;

   typedef struct packed {
      logic               en;
      logic [RING_AW-1:0] addr;
      logic [FRAME_W-1:0] data;
   } wr_type;

endpackage

// ===== rtl/audio_ring_writer_with_rate_feedback_unit.sv =====
// Audio frame ring writer with rate feedback.
// Request channel (req_*): one beat per operation: write frame, feedback
// tick, restart ring, read frame or stop stream, with the stereo samples,
// packet flags and the playback read position.
// Response channel (rsp_*): exactly one beat per request beat, in order,
// carrying read samples, the 6.14 feedback value, the fill level and a
// restart flag.
// Requests wait in the input register until the response register is
// free. Throughput: one request per cycle unless stalled; the frame store
// is a 1024 x 32 RAM with one write and one registered read port, read at
// accept time and forwarded past a same-address write. An attached
// restart empties the ring at once: range counters mark which entries
// were written since the last clear, so no clearing pass is needed.
// Reset: ring detached, unmuted, stream stopped, write position zero, ring
// reads back as zero; requests are taken from the first cycle after reset.
// Stall: if rsp_ready stays low, one more request is taken into the input
// register, then req_ready drops until the response beat is taken.
// Registers (APB, 4-byte spaced): 0 ring_attached, 1 mute; write them idle.
module audio_ring_writer_with_rate_feedback_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [arwf_pkg::OP_W-1:0]             req_operation,
   input  logic signed [arwf_pkg::SAMPLE_W-1:0]  req_left_sample,
   input  logic signed [arwf_pkg::SAMPLE_W-1:0]  req_right_sample,
   input  logic                                  req_first_of_packet,
   input  logic [arwf_pkg::COUNT_W-1:0]          req_packet_frames,
   input  logic [arwf_pkg::RING_AW-1:0]          req_read_frame,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [arwf_pkg::SAMPLE_W-1:0]  rsp_play_left,
   output logic signed [arwf_pkg::SAMPLE_W-1:0]  rsp_play_right,
   output logic [arwf_pkg::FB_W-1:0]             rsp_feedback_value,
   output logic [arwf_pkg::RING_AW-1:0]          rsp_fill_frames,
   output logic                                  rsp_ring_restarted,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [arwf_pkg::CSR_AW-1:0]           paddr,
   input  logic [arwf_pkg::CSR_DW-1:0]           pwdata,
   output logic [arwf_pkg::CSR_DW-1:0]           prdata,
   output logic                                  pready
);
   import arwf_pkg::*;

   cfg_type            cfg;
   wr_type             wr;
   result_type         res;
   item_type           s1_item_ff;
   logic               s1_valid_ff;
   result_type         rsp_res_ff;
   logic               rsp_valid_ff;
   logic               byp_hit_ff;
   logic [FRAME_W-1:0] byp_data_ff;
   logic [FRAME_W-1:0] ram_rd_data;
   logic [FRAME_W-1:0] rd_data;
   logic               accept;
   logic               go;
   logic               ram_we;

   assign go        = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || go;
   assign accept    = req_valid && req_ready;
   assign ram_we    = go && wr.en;

   arwf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   arwf_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (RING_FRAMES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (accept),
      .rd_addr (req_read_frame),
      .rd_data (ram_rd_data)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (go) begin
         s1_valid_ff <= 1'b0;
      end
      if (accept) begin
         s1_item_ff.op    <= req_operation;
         s1_item_ff.left  <= req_left_sample;
         s1_item_ff.right <= req_right_sample;
         s1_item_ff.first <= req_first_of_packet;
         s1_item_ff.count <= req_packet_frames;
         s1_item_ff.rd    <= req_read_frame;
      end
   end

   // forward a frame written in the same cycle the read was issued
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_hit_ff <= 1'b0;
      end else if (accept) begin
         byp_hit_ff <= ram_we && (wr.addr == req_read_frame);
      end
      if (accept) begin
         byp_data_ff <= wr.data;
      end
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : ram_rd_data;

   arwf_core u_core (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .item    (s1_item_ff),
      .rd_data (rd_data),
      .cfg     (cfg),
      .wr      (wr),
      .res     (res)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (go) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_play_left      = rsp_res_ff.play_left;
   assign rsp_play_right     = rsp_res_ff.play_right;
   assign rsp_feedback_value = rsp_res_ff.feedback;
   assign rsp_fill_frames    = rsp_res_ff.fill;
   assign rsp_ring_restarted = rsp_res_ff.restarted;

endmodule

// ===== rtl/arwf_ram.sv =====
module arwf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/arwf_csr.sv =====
module arwf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [arwf_pkg::CSR_AW-1:0]   paddr,
   input  logic [arwf_pkg::CSR_DW-1:0]   pwdata,
   output logic [arwf_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready,
   output arwf_pkg::cfg_type             cfg
);
   import arwf_pkg::*;

   logic        attached_ff;
   logic        mute_ff;
   logic        wr_strobe;
   csr_idx_type idx;

   assign wr_strobe = psel && penable && pwrite;
   assign idx       = csr_idx_type'(paddr[CSR_AW-1]);
   assign pready    = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         attached_ff <= 1'b0;
         mute_ff     <= 1'b0;
      end else if (wr_strobe) begin
         unique case (idx)
            CSR_RING_ATTACHED: attached_ff <= pwdata[0];
            CSR_MUTE:          mute_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      prdata = '0;
      unique case (idx)
         CSR_RING_ATTACHED: prdata[0] = attached_ff;
         CSR_MUTE:          prdata[0] = mute_ff;
         default: ;
      endcase
   end

   assign cfg.attached  = attached_ff;
   assign cfg.mute      = mute_ff;
   assign cfg.attach_wr = wr_strobe && (idx == CSR_RING_ATTACHED);

endmodule

// ===== rtl/arwf_core.sv =====
module arwf_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  arwf_pkg::item_type            item,
   input  logic [arwf_pkg::FRAME_W-1:0]  rd_data,
   input  arwf_pkg::cfg_type             cfg,
   output arwf_pkg::wr_type              wr,
   output arwf_pkg::result_type          res
);
   import arwf_pkg::*;

   localparam logic signed [CORR_W-1:0] CORR_MAX = CORR_W'(FB_MAX_CORR);
   localparam logic signed [CORR_W-1:0] CORR_MIN = -CORR_MAX;
   localparam logic [CNT_W:0]  WR_UPPER   = (CNT_W+1)'(RING_FRAMES - GUARD_BAND);
   localparam logic [RING_AW-1:0] TICK_UPPER = RING_AW'(RING_FRAMES - GUARD_BAND);
   localparam logic [RING_AW-1:0] GUARD_LIM  = RING_AW'(GUARD_BAND);
   localparam logic [RING_AW-1:0] HALF_OFS   = RING_AW'(HALF_RING);
   localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(RING_FRAMES);

   // ring state; written region since the last clear is tracked as
   // range a (from start_a) and range b (from zero, after a detached restart)
   logic [RING_AW-1:0] wp_ff, wp_in;
   logic               started_ff, started_in;
   logic [RING_AW-1:0] start_a_ff, start_a_in;
   logic [CNT_W-1:0]   cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0]   cnt_b_ff, cnt_b_in;
   logic               mode_b_ff, mode_b_in;

   logic [RING_AW-1:0]        fill_pre;
   logic [RING_AW-1:0]        wp_clear;
   logic [RING_AW-1:0]        wp_wr;
   logic                      too_low;
   logic                      wr_too_high;
   logic                      tick_too_high;
   logic                      clear;
   logic [RING_AW-1:0]        rel_a;
   logic                      entry_valid;
   logic [RING_AW-1:0]        fill_tick;
   logic signed [CNT_W-1:0]   fill_err;
   logic signed [CORR_W-1:0]  corr_raw;
   logic signed [CORR_W-1:0]  corr;
   logic [CNT_W-1:0]          wr_end;

   assign fill_pre      = wp_ff - item.rd;
   assign wp_clear      = item.rd + HALF_OFS;
   assign too_low       = fill_pre < GUARD_LIM;
   assign wr_too_high   = ((CNT_W+1)'(fill_pre) + (CNT_W+1)'(item.count)) > WR_UPPER;
   assign tick_too_high = fill_pre > TICK_UPPER;

   // stored entry counts only if written since the last clear
   assign rel_a       = item.rd - start_a_ff;
   assign entry_valid = (CNT_W'(rel_a) < cnt_a_ff) || (CNT_W'(item.rd) < cnt_b_ff);

   // feedback correction: -8 * (fill - half ring), clamped
   assign fill_err = $signed(CNT_W'(fill_tick)) - $signed(CNT_W'(HALF_RING));
   assign corr_raw = -($signed(CORR_W'(fill_err)) <<< FB_GAIN_SH);
   always_comb begin
      priority if (corr_raw > CORR_MAX) begin
         corr = CORR_MAX;
      end else if (corr_raw < CORR_MIN) begin
         corr = CORR_MIN;
      end else begin
         corr = corr_raw;
      end
   end

   // one item's state update and result
   always_comb begin
      wp_in      = wp_ff;
      started_in = started_ff;
      start_a_in = start_a_ff;
      cnt_a_in   = cnt_a_ff;
      cnt_b_in   = cnt_b_ff;
      mode_b_in  = mode_b_ff;
      clear      = 1'b0;
      wp_wr      = wp_ff;
      fill_tick  = fill_pre;
      wr_end     = '0;
      wr.en      = 1'b0;
      wr.addr    = wp_ff;
      wr.data    = cfg.mute ? '0 : {item.right, item.left};
      res        = '0;

      unique case (item.op)
         OP_WRITE: begin
            if (cfg.attached && (item.count != '0)) begin
               if (item.first && (!started_ff || too_low || wr_too_high)) begin
                  clear = 1'b1;
                  wp_wr = wp_clear;
               end
               wr.en   = 1'b1;
               wr.addr = wp_wr;
               wp_in   = wp_wr + RING_AW'(1);
            end
         end
         OP_TICK: begin
            res.feedback = FB_NOMINAL;
            if (cfg.attached && started_ff) begin
               if (too_low || tick_too_high) begin
                  clear     = 1'b1;
                  wp_in     = wp_clear;
                  fill_tick = HALF_OFS;
               end
               res.feedback = FB_NOMINAL + FB_W'(corr);
            end
         end
         OP_RESTART: begin
            if (cfg.attached) begin
               clear = 1'b1;
               wp_in = wp_clear;
            end else begin
               started_in = 1'b0;
               wp_in      = '0;
               mode_b_in  = 1'b1;
            end
         end
         OP_READ: begin
            if (cfg.attached && entry_valid) begin
               res.play_left  = rd_data[SAMPLE_W-1:0];
               res.play_right = rd_data[FRAME_W-1:SAMPLE_W];
            end
         end
         OP_STOP: begin
            started_in = 1'b0;
         end
         default: ;
      endcase

      // clear empties both tracked ranges
      if (clear) begin
         started_in = 1'b1;
         start_a_in = wp_clear;
         cnt_a_in   = '0;
         cnt_b_in   = '0;
         mode_b_in  = 1'b0;
      end

      // extend the range the write lands in
      if (wr.en) begin
         wr_end = CNT_W'(wr.addr) + CNT_W'(1);
         if (mode_b_in) begin
            if (wr_end > cnt_b_in) begin
               cnt_b_in = wr_end;
            end
         end else if (cnt_a_in != CNT_FULL) begin
            cnt_a_in = cnt_a_in + CNT_W'(1);
         end
      end

      res.restarted = clear;
      res.fill      = cfg.attached ? (wp_in - item.rd) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         started_ff <= 1'b0;
         start_a_ff <= '0;
         cnt_a_ff   <= '0;
         cnt_b_ff   <= '0;
         mode_b_ff  <= 1'b0;
      end else if (go) begin
         wp_ff      <= wp_in;
         started_ff <= started_in;
         start_a_ff <= start_a_in;
         cnt_a_ff   <= cnt_a_in;
         cnt_b_ff   <= cnt_b_in;
         mode_b_ff  <= mode_b_in;
      end else if (cfg.attach_wr) begin
         started_ff <= 1'b0;
      end
   end

endmodule

// ===== test/tb_audio_ring_writer_with_rate_feedback_unit.sv =====
module tb_audio_ring_writer_with_rate_feedback_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import arwf_pkg::*;

   localparam int RING        = 1024;
   localparam int GUARD       = 96;
   localparam int FB_GAIN     = 8;
   localparam int CORR_MAX    = 4096;
   localparam logic [FB_W-1:0] FB_NOM = FB_W'(48 << 14);
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   localparam int HOLD_CYCLES = 60;

   // operation codes the block leaves alone
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [OP_W-1:0]            req_operation = '0;
   logic signed [SAMPLE_W-1:0] req_left_sample = '0;
   logic signed [SAMPLE_W-1:0] req_right_sample = '0;
   logic                       req_first_of_packet = 1'b0;
   logic [COUNT_W-1:0]         req_packet_frames = '0;
   logic [RING_AW-1:0]         req_read_frame = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_play_left;
   logic signed [SAMPLE_W-1:0] rsp_play_right;
   logic [FB_W-1:0]            rsp_feedback_value;
   logic [RING_AW-1:0]         rsp_fill_frames;
   logic                       rsp_ring_restarted;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [CSR_AW-1:0]          paddr = '0;
   logic [CSR_DW-1:0]          pwdata = '0;
   logic [CSR_DW-1:0]          prdata;
   logic                       pready;

   audio_ring_writer_with_rate_feedback_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_left_sample     (req_left_sample),
      .req_right_sample    (req_right_sample),
      .req_first_of_packet (req_first_of_packet),
      .req_packet_frames   (req_packet_frames),
      .req_read_frame      (req_read_frame),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_play_left       (rsp_play_left),
      .rsp_play_right      (rsp_play_right),
      .rsp_feedback_value  (rsp_feedback_value),
      .rsp_fill_frames     (rsp_fill_frames),
      .rsp_ring_restarted  (rsp_ring_restarted),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always #1 clock = ~clock;

   // shadow of the ring and its control state
   logic [FRAME_W-1:0] ring_mem [RING];
   logic [RING_AW-1:0] wr_pos = '0;
   bit                 stream_on = 1'b0;
   bit                 ring_on = 1'b0;
   bit                 mute_on = 1'b0;

   item_type   frame_requests[$];
   result_type pending_replies[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left = 0;
   bit req_took = 1'b0;

   int mismatch_count = 0;
   int beats_taken = 0;
   int replies_seen = 0;
   int realigns_seen = 0;
   int held_off_cycles = 0;
   int quiet_cycles = 0;

   // stimulus-side guess of where the block writes next
   logic [RING_AW-1:0] gen_wp = '0;
   bit                 gen_on = 1'b0;
   int                 pkt_left = 0;
   int                 pkt_count = 1;

   // if attached, clear the ring, write position half a ring ahead of playback
   function automatic bit realign_ring(input logic [RING_AW-1:0] rd);
      if (!ring_on) begin
         stream_on = 1'b0;
         wr_pos = '0;
         return 1'b0;
      end
      foreach (ring_mem[i]) ring_mem[i] = '0;
      wr_pos = rd + RING_AW'(RING / 2);
      stream_on = 1'b1;
      return 1'b1;
   endfunction

   function automatic result_type predict_ring_step(input item_type it);
      result_type         r;
      logic [RING_AW-1:0] fill;
      int                 err;
      int                 corr;
      r = '0;
      fill = wr_pos - it.rd;
      case (it.op)
         OP_WRITE: begin
            if (ring_on && it.count != 0) begin
               // level check only on a packet's first frame, with room for the packet
               if (it.first && (!stream_on || int'(fill) < GUARD ||
                                int'(fill) > RING - GUARD - int'(it.count)))
                  r.restarted = realign_ring(it.rd);
               ring_mem[wr_pos] = mute_on ? '0 : {it.right, it.left};
               wr_pos = wr_pos + 1'b1;
            end
         end
         OP_TICK: begin
            corr = 0;
            if (ring_on && stream_on) begin
               if (int'(fill) < GUARD || int'(fill) > RING - GUARD)
                  r.restarted = realign_ring(it.rd);
               fill = wr_pos - it.rd;
               err = int'(fill) - RING / 2;
               corr = -(err * FB_GAIN);
               if (corr > CORR_MAX)
                  corr = CORR_MAX;
               else if (corr < -CORR_MAX)
                  corr = -CORR_MAX;
            end
            r.feedback = FB_NOM + FB_W'(corr);
         end
         OP_RESTART: r.restarted = realign_ring(it.rd);
         OP_READ: begin
            if (ring_on)
               {r.play_right, r.play_left} = ring_mem[it.rd];
         end
         OP_STOP: stream_on = 1'b0;
         default: ;
      endcase
      r.fill = ring_on ? RING_AW'(wr_pos - it.rd) : '0;
      return r;
   endfunction

   // request driver
   always @(negedge clock) begin
      item_type next_req;
      if (!req_valid || req_took) begin
         if (frame_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = frame_requests.pop_front();
            req_valid           <= 1'b1;
            req_operation       <= next_req.op;
            req_left_sample     <= next_req.left;
            req_right_sample    <= next_req.right;
            req_first_of_packet <= next_req.first;
            req_packet_frames   <= next_req.count;
            req_read_frame      <= next_req.rd;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response backpressure, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // accepted request beats feed the predictor
   always @(posedge clock) begin
      item_type taken;
      req_took <= !reset && req_valid && req_ready;
      if (!reset && req_valid && !req_ready)
         held_off_cycles++;
      if (!reset && req_valid && req_ready) begin
         taken.op    = req_operation;
         taken.left  = req_left_sample;
         taken.right = req_right_sample;
         taken.first = req_first_of_packet;
         taken.count = req_packet_frames;
         taken.rd    = req_read_frame;
         pending_replies.push_back(predict_ring_step(taken));
         beats_taken++;
      end
   end

   // response monitor
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.play_left  = rsp_play_left;
         got.play_right = rsp_play_right;
         got.feedback   = rsp_feedback_value;
         got.fill       = rsp_fill_frames;
         got.restarted  = rsp_ring_restarted;
         replies_seen++;
         if (got.restarted)
            realigns_seen++;
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: response beat with nothing pending", $realtime);
         end else begin
            want = pending_replies.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: beat %0d want %h/%h/%h/%0d/%0b got %h/%h/%h/%0d/%0b",
                           $realtime, replies_seen, want.play_left, want.play_right,
                           want.feedback, want.fill, want.restarted, got.play_left,
                           got.play_right, got.feedback, got.fill, got.restarted);
            end
         end
      end
   end

   // watchdog on cycles with no beat on any port
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", quiet_cycles);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_req(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] left,
                           input logic [SAMPLE_W-1:0] right, input logic first,
                           input logic [COUNT_W-1:0] count, input logic [RING_AW-1:0] rd);
      item_type it;
      it.op    = op;
      it.left  = left;
      it.right = right;
      it.first = first;
      it.count = count;
      it.rd    = rd;
      frame_requests.push_back(it);
   endtask

   task automatic apb_transfer(input bit wr, input logic [CSR_AW-1:0] addr,
                               input logic [CSR_DW-1:0] wdata,
                               output logic [CSR_DW-1:0] rdata);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = wr;
      paddr   = addr;
      pwdata  = wdata;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // write a register, mirror it, and read it back
   task automatic set_register(input csr_idx_type idx, input bit value);
      logic [CSR_AW-1:0] addr;
      logic [CSR_DW-1:0] readback;
      addr = CSR_AW'(4 * int'(idx));
      apb_transfer(1'b1, addr, CSR_DW'(value), readback);
      if (idx == CSR_RING_ATTACHED) begin
         ring_on   = value;
         stream_on = 1'b0;
      end else begin
         mute_on = value;
      end
      apb_transfer(1'b0, addr, '0, readback);
      if (readback !== CSR_DW'(value)) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: register %0d reads %h, want %0b", $realtime, idx, readback, value);
      end
   endtask

   task automatic wait_idle();
      while (frame_requests.size() != 0 || req_valid || pending_replies.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // mostly well-formed packet streams with playback near half a ring behind
   task automatic queue_random_beats(input int n);
      int                 pick;
      int                 jit;
      logic [RING_AW-1:0] rd;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            jit = int'($urandom_range(600)) - 300;
            rd = gen_wp - RING_AW'(RING / 2 + jit);
            if (pkt_left == 0) begin
               pkt_count = ($urandom_range(19) == 0) ? $urandom_range(50, 63)
                                                     : $urandom_range(1, 49);
               pkt_left = pkt_count;
               // occasional broken level, which may force a realign
               if ($urandom_range(9) == 0)
                  rd = RING_AW'($urandom);
               if (!gen_on || (gen_wp - rd) != RING_AW'(RING / 2 + jit))
                  gen_wp = rd + RING_AW'(RING / 2);
               gen_on = 1'b1;
               push_req(OP_WRITE, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'b1,
                        COUNT_W'(pkt_count), rd);
            end else begin
               push_req(OP_WRITE, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'b0,
                        COUNT_W'(pkt_count), rd);
            end
            pkt_left--;
            gen_wp = gen_wp + 1'b1;
         end else if (pick < 75) begin
            // tick with a level that sometimes drifts out of the guard band
            jit = int'($urandom_range(900)) - 450;
            rd = gen_wp - RING_AW'(RING / 2 + jit);
            if (gen_on && (jit > RING / 2 - GUARD || jit < GUARD - RING / 2))
               gen_wp = rd + RING_AW'(RING / 2);
            push_req(OP_TICK, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                     1'($urandom_range(1)), COUNT_W'($urandom), rd);
         end else if (pick < 90) begin
            rd = ($urandom_range(4) != 0) ? gen_wp - RING_AW'($urandom_range(1, 64))
                                          : RING_AW'($urandom);
            push_req(OP_READ, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                     1'($urandom_range(1)), COUNT_W'($urandom), rd);
         end else if (pick < 95) begin
            rd = RING_AW'($urandom);
            gen_wp = rd + RING_AW'(RING / 2);
            gen_on = 1'b1;
            pkt_left = 0;
            push_req(OP_RESTART, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                     1'($urandom_range(1)), COUNT_W'($urandom), rd);
         end else if (pick < 97) begin
            gen_on = 1'b0;
            pkt_left = 0;
            push_req(OP_STOP, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                     1'($urandom_range(1)), COUNT_W'($urandom), RING_AW'($urandom));
         end else begin
            // noise: any code, any fields
            push_req(OP_W'($urandom_range(OP_SPARE_C)), SAMPLE_W'($urandom),
                     SAMPLE_W'($urandom), 1'($urandom_range(1)), COUNT_W'($urandom),
                     RING_AW'($urandom));
         end
      end
   endtask

   initial begin
      int beats;
      bit attach_val;
      bit mute_val;
      foreach (ring_mem[i]) ring_mem[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // no ring attached: everything is a no-op or a zero, a tick gives nominal feedback
      push_req(OP_WRITE, 16'h7FFF, 16'h8000, 1'b1, 6'd1, 10'd0);
      push_req(OP_READ, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd0);
      push_req(OP_TICK, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd5);
      push_req(OP_RESTART, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd100);
      push_req(OP_STOP, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd0);
      push_req(OP_SPARE_A, 16'h1234, 16'hFFFF, 1'b1, 6'd63, 10'd1023);
      push_req(OP_SPARE_B, 16'hFFFF, 16'h0000, 1'b0, 6'd0, 10'd512);
      push_req(OP_SPARE_C, 16'h8000, 16'h7FFF, 1'b1, 6'd49, 10'd1);
      wait_idle();

      set_register(CSR_RING_ATTACHED, 1'b1);
      set_register(CSR_MUTE, 1'b0);

      // tick before start, first frame starts the stream, extremes of samples
      push_req(OP_TICK, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd0);
      push_req(OP_WRITE, 16'h7FFF, 16'h8000, 1'b1, 6'd49, 10'd1023);
      push_req(OP_WRITE, 16'h8000, 16'h7FFF, 1'b0, 6'd49, 10'd1023);
      push_req(OP_WRITE, 16'hFFFF, 16'hFFFF, 1'b0, 6'd0, 10'd1023);
      push_req(OP_WRITE, 16'hFFFF, 16'h0000, 1'b0, 6'd63, 10'd1023);
      push_req(OP_READ, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd511);
      push_req(OP_READ, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd512);
      push_req(OP_READ, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd513);
      push_req(OP_READ, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd514);
      // in-band tick, then one above the band
      push_req(OP_TICK, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd1023);
      push_req(OP_TICK, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd600);
      // first frame with the level below the band
      push_req(OP_WRITE, 16'h0001, 16'h0002, 1'b1, 6'd1, 10'd88);
      push_req(OP_READ, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd511);
      push_req(OP_RESTART, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd1023);
      push_req(OP_STOP, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd0);
      push_req(OP_TICK, 16'h0000, 16'h0000, 1'b0, 6'd1, 10'd0);
      wait_idle();

      // random phases over register settings and pacing
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin beats = 70; attach_val = 1; mute_val = 0;
                     send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin beats = 70; attach_val = 1; mute_val = 1;
                     send_idle_pct = 80; rsp_stall_pct = 0;  end
            2: begin beats = 70; attach_val = 1; mute_val = 0;
                     send_idle_pct = 0;  rsp_stall_pct = 80; end
            3: begin beats = 30; attach_val = 0; mute_val = 1;
                     send_idle_pct = 13; rsp_stall_pct = 13; end
            4: begin beats = 70; attach_val = 1; mute_val = 1;
                     send_idle_pct = 13; rsp_stall_pct = 13; end
            default: begin beats = 90; attach_val = 1; mute_val = 0;
                     send_idle_pct = 0;  rsp_stall_pct = 0;  end
         endcase
         set_register(CSR_MUTE, mute_val);
         set_register(CSR_RING_ATTACHED, attach_val);
         gen_on = 1'b0;
         pkt_left = 0;
         // last phase: hold the response side off while requests pile up
         if (p == 5)
            hold_left = HOLD_CYCLES;
         queue_random_beats(beats);
         wait_idle();
      end

      repeat (5) @(posedge clock);
      $display("covered %0d request beats and %0d response beats, %0d ring realigns",
               beats_taken, replies_seen, realigns_seen);
      $display("input held off %0d cycles by backpressure; %0d mismatches, %0d left pending",
               held_off_cycles, mismatch_count, pending_replies.size());
      if (mismatch_count == 0 && pending_replies.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
